### hw/rtl/sasg_pkg.sv
package sasg_pkg;

    // default sizing of the block
    localparam int MAX_SEQ_LEN_DEF  = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed field widths
    localparam int CFG_W  = 7;
    localparam int DROP_W = 32;

    // front queue depth, a power of two
    localparam int QUEUE_DEPTH = 4;

    // remainder unit: bits of the drop count folded in per cycle
    localparam int MOD_BITS = 4;

    // back end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_RELEASE
    } t_back_state;

endpackage

### hw/rtl/sasg_front.sv
module sasg_front #(
    parameter int SAMPLE_WIDTH = sasg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_q,
    input  logic                           i_gap_before,
    input  logic [sasg_pkg::DROP_W-1:0]    i_dropped_count,
    output logic                           o_q_valid,
    input  logic                           i_q_pop,
    output logic signed [SAMPLE_WIDTH-1:0] o_q_i,
    output logic signed [SAMPLE_WIDTH-1:0] o_q_q,
    output logic                           o_q_gap,
    output logic [sasg_pkg::DROP_W-1:0]    o_q_drop
);

    localparam int DEPTH = sasg_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int WW    = 2 * SAMPLE_WIDTH + 1 + sasg_pkg::DROP_W;

    logic [WW-1:0] r_word [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;
    logic [WW-1:0] head;
    logic          gap_word;

    // classify: a drop count only matters on a word that follows a gap
    assign gap_word   = i_gap_before;
    assign o_in_ready = (r_count != CW'(DEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_word[r_wr_ptr] <= {i_in_i, i_in_q, gap_word,
                                 gap_word ? i_dropped_count : '0};
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // head of queue
    assign head = r_word[r_rd_ptr];
    assign o_q_i    = head[WW-1 -: SAMPLE_WIDTH];
    assign o_q_q    = head[WW-1-SAMPLE_WIDTH -: SAMPLE_WIDTH];
    assign o_q_gap  = head[sasg_pkg::DROP_W];
    assign o_q_drop = head[sasg_pkg::DROP_W-1:0];

endmodule

### hw/rtl/sasg_mod.sv
module sasg_mod #(
    parameter int MAX_SEQ_LEN = sasg_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [sasg_pkg::DROP_W-1:0]      i_drop,
    input  logic [$clog2(MAX_SEQ_LEN+1)-1:0] i_len,
    output logic                             o_done,
    output logic [$clog2(MAX_SEQ_LEN+1)-1:0] o_rem
);

    localparam int LW    = $clog2(MAX_SEQ_LEN + 1);
    localparam int DW    = sasg_pkg::DROP_W;
    localparam int NB    = sasg_pkg::MOD_BITS;
    localparam int STEPS = DW / NB;
    localparam int SW    = $clog2(STEPS);

    logic [LW-1:0] r_rem;
    logic [DW-1:0] r_shift;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_done;
    logic [LW-1:0] n_rem;

    // fold the next MOD_BITS dividend bits into the remainder, msb first
    always_comb begin
        logic [LW:0]   t;
        logic [LW-1:0] acc;
        acc = r_rem;
        t   = '0;
        for (int k = 0; k < NB; k++) begin
            t = {acc, r_shift[DW-1-k]};
            if (t >= {1'b0, i_len}) begin
                t = t - {1'b0, i_len};
            end
            acc = t[LW-1:0];
        end
        n_rem = acc;
    end

    // remainder datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_drop;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_shift <= r_shift << NB;
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SW'(STEPS - 1);
            end else if (r_busy) begin
                r_step <= r_step - SW'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hw/rtl/sasg_back.sv
module sasg_back #(
    parameter int MAX_SEQ_LEN  = sasg_pkg::MAX_SEQ_LEN_DEF,
    parameter int SAMPLE_WIDTH = sasg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sasg_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_q_valid,
    output logic                             o_q_pop,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_q_i,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_q_q,
    input  logic                             i_q_gap,
    output logic                             o_mod_start,
    output logic [$clog2(MAX_SEQ_LEN+1)-1:0] o_len,
    input  logic                             i_mod_done,
    input  logic [$clog2(MAX_SEQ_LEN+1)-1:0] i_mod_rem,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0]   o_out_q,
    output logic                             o_seq_last
);

    localparam int LW = $clog2(MAX_SEQ_LEN + 1);
    localparam int AW = $clog2(MAX_SEQ_LEN);
    localparam int CW = sasg_pkg::CFG_W;

    sasg_pkg::t_back_state r_state, n_state;

    logic [2*SAMPLE_WIDTH-1:0] r_mem [MAX_SEQ_LEN];
    logic [LW-1:0]             r_len;
    logic [AW-1:0]             r_fill, n_fill;
    logic [AW-1:0]             r_skip, n_skip;
    logic [AW-1:0]             r_rd, n_rd;
    logic                      r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_i;
    logic signed [SAMPLE_WIDTH-1:0] r_out_q;
    logic                      r_out_last;
    logic [LW-1:0]             cfg_len;
    logic [AW-1:0]             fill_use;
    logic [AW-1:0]             skip_use;
    logic                      proc;
    logic                      wr_en;
    logic                      rd_en;
    logic                      rd_last;
    logic                      q_pop;
    logic                      mod_start;

    // effective length of a register write: zero acts as one, clamp at max
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_len = LW'(1);
        end else if (i_cfg_data > CW'(MAX_SEQ_LEN)) begin
            cfg_len = LW'(MAX_SEQ_LEN);
        end else begin
            cfg_len = LW'(i_cfg_data);
        end
    end

    assign rd_last = (LW'(r_rd) == r_len - LW'(1));

    // sequencer: next state and controls
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_skip    = r_skip;
        n_rd      = r_rd;
        fill_use  = r_fill;
        skip_use  = r_skip;
        proc      = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        q_pop     = 1'b0;
        mod_start = 1'b0;
        case (r_state)
            sasg_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_gap) begin
                        mod_start = 1'b1;
                        n_state   = sasg_pkg::S_MOD;
                    end else begin
                        proc = 1'b1;
                    end
                end
            end
            sasg_pkg::S_MOD: begin
                // gap: drop partial sequence, skip to the next boundary
                if (i_mod_done) begin
                    proc     = 1'b1;
                    fill_use = '0;
                    skip_use = (i_mod_rem == '0) ? '0 : AW'(r_len - i_mod_rem);
                end
            end
            sasg_pkg::S_RELEASE: begin
                if (!r_out_valid || i_out_ready) begin
                    rd_en = 1'b1;
                    n_rd  = r_rd + AW'(1);
                    if (rd_last) begin
                        n_rd    = '0;
                        n_state = sasg_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sasg_pkg::S_IDLE;
            end
        endcase

        // take the head word: skip it or store it
        if (proc) begin
            q_pop   = 1'b1;
            n_state = sasg_pkg::S_IDLE;
            n_fill  = fill_use;
            if (skip_use != '0) begin
                n_skip = skip_use - AW'(1);
            end else begin
                wr_en  = 1'b1;
                n_skip = '0;
                if (LW'(fill_use) == r_len - LW'(1)) begin
                    n_fill  = '0;
                    n_rd    = '0;
                    n_state = sasg_pkg::S_RELEASE;
                end else begin
                    n_fill = fill_use + AW'(1);
                end
            end
        end

        // a length write restarts collection
        if (i_cfg_we) begin
            n_fill = '0;
            n_skip = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sasg_pkg::S_IDLE;
            r_len       <= LW'(MAX_SEQ_LEN);
            r_fill      <= '0;
            r_skip      <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_skip  <= n_skip;
            r_rd    <= n_rd;
            if (i_cfg_we) begin
                r_len <= cfg_len;
            end
            if (rd_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample store write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[fill_use] <= {i_q_i, i_q_q};
        end
    end

    // sample store read into the output register
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            {r_out_i, r_out_q} <= r_mem[r_rd];
            r_out_last         <= rd_last;
        end
    end

    assign o_q_pop     = q_pop;
    assign o_mod_start = mod_start;
    assign o_len       = r_len;
    assign o_out_valid = r_out_valid;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;
    assign o_seq_last  = r_out_last;

    // checks
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> i_q_valid)
        else $error("pop from empty queue");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_fill) < r_len)
        else $error("fill count beyond sequence length");

    a_skip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_skip) < r_len)
        else $error("skip count beyond sequence length");

    a_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mod_done |-> (r_state == sasg_pkg::S_MOD))
        else $error("remainder done outside gap handling");

    a_release_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && rd_last) |=> (r_state == sasg_pkg::S_IDLE) && o_out_valid && o_seq_last)
        else $error("release did not end on last word");

endmodule

### hw/rtl/sequence_aligned_sample_gate_unit.sv
// flow: a plain word at the queue head is stored while the sequencer is idle; a gap
//   word first waits for the drop-count remainder (4 bits per cycle over 32 bits)
// sequencing: no word is taken from the queue while a sequence is released, so a
//   sequence is fully collected before its release, and each gap adds the remainder wait
// reset: synchronous active low, clears queue, counters, state; length = max;
//   the sample store is not cleared, no clearing pass
module sequence_aligned_sample_gate_unit #(
    parameter int MAX_SEQ_LEN  = sasg_pkg::MAX_SEQ_LEN_DEF,
    parameter int SAMPLE_WIDTH = sasg_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sasg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_in_q,
    input  logic                           i_gap_before,
    input  logic [sasg_pkg::DROP_W-1:0]    i_dropped_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0] o_out_q,
    output logic                           o_seq_last
);

    localparam int LW = $clog2(MAX_SEQ_LEN + 1);

    logic                           q_valid;
    logic                           q_pop;
    logic signed [SAMPLE_WIDTH-1:0] q_i;
    logic signed [SAMPLE_WIDTH-1:0] q_q;
    logic                           q_gap;
    logic [sasg_pkg::DROP_W-1:0]    q_drop;
    logic                           mod_start;
    logic                           mod_done;
    logic [LW-1:0]                  mod_rem;
    logic [LW-1:0]                  len;

    // front: accept and queue words
    sasg_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_i         (i_in_i),
        .i_in_q         (i_in_q),
        .i_gap_before   (i_gap_before),
        .i_dropped_count(i_dropped_count),
        .o_q_valid      (q_valid),
        .i_q_pop        (q_pop),
        .o_q_i          (q_i),
        .o_q_q          (q_q),
        .o_q_gap        (q_gap),
        .o_q_drop       (q_drop)
    );

    // drop count modulo sequence length
    sasg_mod #(
        .MAX_SEQ_LEN(MAX_SEQ_LEN)
    ) u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mod_start),
        .i_drop (q_drop),
        .i_len  (len),
        .o_done (mod_done),
        .o_rem  (mod_rem)
    );

    // back: collect, align and release sequences
    sasg_back #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_i      (q_i),
        .i_q_q      (q_q),
        .i_q_gap    (q_gap),
        .o_mod_start(mod_start),
        .o_len      (len),
        .i_mod_done (mod_done),
        .i_mod_rem  (mod_rem),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_i    (o_out_i),
        .o_out_q    (o_out_q),
        .o_seq_last (o_seq_last)
    );

endmodule

### bench/sasg_release_checker.sv
`timescale 1ns / 100ps

module sasg_release_checker (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_cfg_we,
    input  logic [sasg_pkg::CFG_W-1:0]                     i_cfg_data,
    input  logic                                           i_in_valid,
    input  logic                                           i_in_ready,
    input  logic signed [sasg_pkg::SAMPLE_WIDTH_DEF-1:0]   i_in_i,
    input  logic signed [sasg_pkg::SAMPLE_WIDTH_DEF-1:0]   i_in_q,
    input  logic                                           i_gap_before,
    input  logic [sasg_pkg::DROP_W-1:0]                    i_dropped_count,
    input  logic                                           i_out_valid,
    input  logic                                           i_out_ready,
    input  logic signed [sasg_pkg::SAMPLE_WIDTH_DEF-1:0]   i_out_i,
    input  logic signed [sasg_pkg::SAMPLE_WIDTH_DEF-1:0]   i_out_q,
    input  logic                                           i_seq_last,
    output int                                             o_fail_count,
    output int                                             o_pending,
    output int                                             o_released
);

    localparam int W   = sasg_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAX = sasg_pkg::MAX_SEQ_LEN_DEF;

    typedef struct packed {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                last;
    } t_gated_word;

    // predicted gate state
    logic signed [W-1:0]       held_i [MAX];
    logic signed [W-1:0]       held_q [MAX];
    logic [sasg_pkg::CFG_W-1:0] seq_len = sasg_pkg::CFG_W'(MAX);
    int unsigned               fill = 0;
    int unsigned               skip = 0;
    t_gated_word               release_q [$];
    t_gated_word               want;

    int fail_count = 0;
    int waiting    = 0;
    int released   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = waiting;
    assign o_released   = released;

    // one accepted sample through the gate, queuing any released sequence
    task automatic gate_sample(input logic signed [W-1:0] si, input logic signed [W-1:0] sq,
                               input logic gap, input logic [sasg_pkg::DROP_W-1:0] drop);
        int unsigned span;
        span = (seq_len == 0) ? 1 : ((seq_len > MAX) ? MAX : seq_len);
        // gap: drop partial sequence and realign to a boundary
        if (gap) begin
            fill = 0;
            skip = (span - drop % span) % span;
        end
        if (skip > 0) begin
            skip--;
            return;
        end
        if (fill >= span) fill = 0;
        held_i[fill] = si;
        held_q[fill] = sq;
        fill++;
        // full sequence: release in arrival order, mark the final word
        if (fill == span) begin
            for (int k = 0; k < span; k++) begin
                release_q.insert(release_q.size(),
                                 t_gated_word'{held_i[k], held_q[k], (k + 1 == span)});
            end
            fill = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_len = sasg_pkg::CFG_W'(MAX);
            fill    = 0;
            skip    = 0;
            release_q.delete();
        end else begin
            // compare each released word with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                released++;
                if (release_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: word with none expected: i=%0d q=%0d last=%0b",
                                 $realtime, i_out_i, i_out_q, i_seq_last);
                    end
                    fail_count++;
                end else begin
                    want = release_q[0];
                    release_q.delete(0);
                    if (want.re !== i_out_i || want.im !== i_out_q ||
                        want.last !== i_seq_last) begin
                        if (fail_count < 10) begin
                            $display("%0t: word mismatch: expected i=%0d q=%0d last=%0b,",
                                     $realtime, want.re, want.im, want.last);
                            $display("    got i=%0d q=%0d last=%0b",
                                     i_out_i, i_out_q, i_seq_last);
                        end
                        fail_count++;
                    end
                end
            end
            // length write drops partial sequence and pending skip
            if (i_cfg_we) begin
                seq_len = i_cfg_data;
                fill    = 0;
                skip    = 0;
            end
            if (i_in_valid && i_in_ready) begin
                gate_sample(i_in_i, i_in_q, i_gap_before, i_dropped_count);
            end
        end
        waiting = release_q.size();
    end

endmodule

### bench/sequence_aligned_sample_gate_unit_tb.sv
`timescale 1ns / 100ps

module sequence_aligned_sample_gate_unit_tb;

    localparam int W             = sasg_pkg::SAMPLE_WIDTH_DEF;
    localparam int MAX           = sasg_pkg::MAX_SEQ_LEN_DEF;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 9;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [sasg_pkg::CFG_W-1:0]  cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic signed [W-1:0]         in_i      = '0;
    logic signed [W-1:0]         in_q      = '0;
    logic                        gap_before = 1'b0;
    logic [sasg_pkg::DROP_W-1:0] dropped   = '0;
    logic                        out_ready = 1'b0;

    logic                        in_ready;
    logic                        out_valid;
    logic signed [W-1:0]         out_i;
    logic signed [W-1:0]         out_q;
    logic                        seq_last;

    int fail_count;
    int pending;
    int released;

    // idling switch shared by both sides, and long receiver hold-off
    logic allow_idle   = 1'b1;
    int   hold_cycles  = 0;
    int   samples_sent = 0;
    int   cycle_count  = 0;

    logic [sasg_pkg::CFG_W-1:0] length_plan [PHASES] =
        '{7'd1, 7'd64, 7'd5, 7'd0, 7'd3, 7'd127, 7'd8, 7'd2, 7'd20};

    sequence_aligned_sample_gate_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_in_i          (in_i),
        .i_in_q          (in_q),
        .i_gap_before    (gap_before),
        .i_dropped_count (dropped),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_i         (out_i),
        .o_out_q         (out_q),
        .o_seq_last      (seq_last)
    );

    sasg_release_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_i          (in_i),
        .i_in_q          (in_q),
        .i_gap_before    (gap_before),
        .i_dropped_count (dropped),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_i         (out_i),
        .i_out_q         (out_q),
        .i_seq_last      (seq_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_released      (released)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
            $display("sequence_aligned_sample_gate_unit test failed");
            $finish;
        end
    end

    // offer one sample word after a random idle if allowed, return at the accepting edge
    task automatic offer_sample(input logic signed [W-1:0] si, input logic signed [W-1:0] sq,
                                input logic gap, input logic [sasg_pkg::DROP_W-1:0] drop);
        int unsigned idle;
        logic        fire;
        idle = allow_idle ? $urandom_range(0, 12) : 0;
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_i       <= si;
        in_q       <= sq;
        gap_before <= gap;
        dropped    <= drop;
        do begin
            @(negedge clk);
            fire = in_ready;
            @(posedge clk);
        end while (!fire);
        samples_sent++;
    endtask

    // stop offering until every predicted word is out, then settle
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        forever begin
            @(negedge clk);
            if (pending == 0) break;
        end
        @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_length(input logic [sasg_pkg::CFG_W-1:0] value);
        wait_drained(SETTLE_CYCLES);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // receiver: random stall per word if idling is allowed, long hold-off on request
    initial begin
        int unsigned stall;
        logic        fire;
        forever begin
            stall = allow_idle ? $urandom_range(0, 12) : 0;
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge clk);
                fire = out_valid;
                @(posedge clk);
            end while (!fire);
        end
    end

    initial begin
        int unsigned                 span;
        int unsigned                 count;
        logic                        gap;
        logic [sasg_pkg::DROP_W-1:0] drop;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero skip, skips, gap during skip, length one
        set_length(7'd4);
        offer_sample(16'sh8000, 16'sh7fff, 1'b0, 32'h0);
        offer_sample(16'sh7fff, 16'sh8000, 1'b0, 32'hffff_ffff);
        offer_sample(16'sh0000, -16'sd1, 1'b0, 32'h0);
        offer_sample(-16'sd1, 16'sh0000, 1'b0, 32'h0);
        // gap with zero skip keeps the flagged word as a new first word
        offer_sample(W'($urandom), W'($urandom), 1'b0, 32'h0);
        offer_sample(W'($urandom), W'($urandom), 1'b0, 32'h0);
        offer_sample(16'sd11, 16'sd12, 1'b1, 32'h0);
        repeat (3) offer_sample(W'($urandom), W'($urandom), 1'b0, 32'h0);
        // skip of three restarted by a second gap with a skip of one
        offer_sample(16'sd21, 16'sd22, 1'b1, 32'h1);
        offer_sample(16'sd23, 16'sd24, 1'b0, 32'h0);
        offer_sample(16'sd25, 16'sd26, 1'b1, 32'hffff_ffff);
        repeat (4) offer_sample(W'($urandom), W'($urandom), 1'b0, 32'h0);
        // length one: every kept word is a whole sequence
        set_length(7'd1);
        offer_sample(W'($urandom), W'($urandom), 1'b0, 32'h0);
        offer_sample(W'($urandom), W'($urandom), 1'b1, 32'h5);
        offer_sample(W'($urandom), W'($urandom), 1'b0, 32'h0);

        // random phases over the length plan
        for (int p = 0; p < PHASES; p++) begin
            set_length(length_plan[p]);
            span = (length_plan[p] == 0) ? 1 :
                   ((length_plan[p] > MAX) ? MAX : length_plan[p]);
            count = span + span / 4 + 8;
            if (count < 24) count = 24;
            allow_idle = !(p == 2 || p == 6);
            // receiver holds off while the sender streams, filling the block
            if (p == 6) hold_cycles = 400;
            for (int n = 0; n < count; n++) begin
                if (p == 4 && n == count / 2) wait_drained(0);
                gap = ($urandom_range(0, 11) == 0);
                case ($urandom_range(0, 3))
                    0:       drop = $urandom_range(0, 3);
                    1:       drop = span * $urandom_range(0, 5000);
                    2:       drop = span * $urandom_range(0, 5000) + $urandom_range(1, 3);
                    default: drop = $urandom;
                endcase
                offer_sample(W'($urandom), W'($urandom), gap, drop);
            end
        end

        wait_drained(SETTLE_CYCLES);
        $display("%0d sample words sent over %0d length settings, %0d words released",
                 samples_sent, PHASES + 2, released);
        $display("directed extremes, gap skips and length limits 0..127 included");
        if (fail_count == 0) begin
            $display("sequence_aligned_sample_gate_unit test passed");
        end else begin
            $display("sequence_aligned_sample_gate_unit test failed");
        end
        $finish;
    end

endmodule
